FILE: rtl/pdf_pkg.sv
// ---------------------------------------------------------------------------
// pdf_pkg - shared types, constants and control store
// Sizes of the count table, the memory port record and the step program
// of the sequencer.
// ---------------------------------------------------------------------------
package pdf_pkg;

  localparam int VALUE_RANGE = 1024;
  localparam int COUNT_WIDTH = 16;
  localparam int ADDR_W      = $clog2(VALUE_RANGE);
  localparam int VALUE_W     = 10;
  localparam int OUT_CNT_W   = 16;
  localparam int STEP_W      = 3;

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [STEP_W-1:0]      step_t;

  localparam count_t COUNT_MAX = '1;

  // One access to the count table per cycle: read at addr, write when we.
  typedef struct packed {
    logic   we;
    addr_t  addr;
    count_t wdata;
  } mem_req_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLASSIFY,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_CHECK,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_START,
    C_SMALL,
    C_SQ_GT,
    C_DIV_MORE,
    C_REM_NZ,
    C_OUT_BUSY
  } cond_t;

  // Next step: cond ? target : (last ? 0 : step + 1)
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  last;
  } ctrl_t;

  localparam step_t S_WAIT     = 3'd0;
  localparam step_t S_CLASSIFY = 3'd1;
  localparam step_t S_DIV_INIT = 3'd2;
  localparam step_t S_DIV_STEP = 3'd3;
  localparam step_t S_DIV_CHK  = 3'd4;
  localparam step_t S_FINISH   = 3'd5;

  function automatic ctrl_t ucode(step_t step);
    ctrl_t w;
    begin
      unique case (step)
        S_WAIT:     w = '{op: OP_LOAD,      cond: C_NO_START, target: S_WAIT,     last: 1'b0};
        S_CLASSIFY: w = '{op: OP_CLASSIFY,  cond: C_SMALL,    target: S_FINISH,   last: 1'b0};
        S_DIV_INIT: w = '{op: OP_DIV_INIT,  cond: C_SQ_GT,    target: S_FINISH,   last: 1'b0};
        S_DIV_STEP: w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE, target: S_DIV_STEP, last: 1'b0};
        S_DIV_CHK:  w = '{op: OP_DIV_CHECK, cond: C_REM_NZ,   target: S_DIV_INIT, last: 1'b0};
        S_FINISH:   w = '{op: OP_FINISH,    cond: C_OUT_BUSY, target: S_FINISH,   last: 1'b1};
        default:    w = '{op: OP_NONE,      cond: C_ALWAYS,   target: S_WAIT,     last: 1'b1};
      endcase
      return w;
    end
  endfunction

endpackage

FILE: rtl/pdf_count_mem.sv
// ---------------------------------------------------------------------------
// pdf_count_mem - per-value count table
// Table with registered read data. After reset it sweeps every
// entry to zero, one per cycle, and holds ready low until the sweep ends.
// ---------------------------------------------------------------------------
module pdf_count_mem
  import pdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output count_t   rd_data,
  output logic     ready
);

  count_t mem [VALUE_RANGE];
  count_t rd_data_r;
  addr_t  clr_addr_r, clr_addr_nxt;
  logic   clr_busy_r, clr_busy_nxt;

  logic   wr_en;
  addr_t  wr_addr;
  count_t wr_data;

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + addr_t'(1);
      if (clr_addr_r == addr_t'(VALUE_RANGE - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  // Clear pass owns the write port until it finishes
  always_comb begin
    wr_en   = clr_busy_r | req.we;
    wr_addr = clr_busy_r ? clr_addr_r : req.addr;
    wr_data = clr_busy_r ? '0 : req.wdata;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[req.addr];
  end

  assign rd_data = rd_data_r;
  assign ready   = ~clr_busy_r;

endmodule

FILE: rtl/prime_duplicate_filter_top.sv
// ---------------------------------------------------------------------------
// prime_duplicate_filter_top - prime test with first-copy filtering
// Sequence: values below 4 or even are classified directly; otherwise each
//   odd trial divisor (3, 5, ... up to sqrt) is tried in turn with a
//   bit-serial remainder, until one divides the value or the square of the
//   divisor exceeds it.
// Throughput: one word at a time; the next word is taken the cycle after
//   the result is registered, even while that result waits on out_tready.
// Reset: a sweep clears the count table; in_tready stays low until it ends.
// ---------------------------------------------------------------------------
module prime_duplicate_filter_top
  import pdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] value
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [0] is_prime, [1] accepted, [17:2] count_after
);

  // Sequencer
  step_t step_r, step_nxt;
  ctrl_t ctrl;

  // Datapath
  logic [VALUE_W-1:0] value_r;
  logic               mode_r;
  logic               prime_r, prime_nxt;
  logic [5:0]         d_r;
  logic [4:0]         rem_r;
  logic [VALUE_W-1:0] dvd_r;
  logic [3:0]         bit_cnt_r;

  logic               out_valid_r;
  logic               out_prime_r;
  logic               out_acc_r;
  logic [OUT_CNT_W-1:0] out_cnt_r;

  mem_req_t mreq;
  count_t   rd_data;
  logic     mem_ready;

  logic     in_fire;
  logic     out_busy;
  logic     short_path;
  logic     sq_gt;
  logic     cond_true;
  logic [11:0] d_sq;
  logic [5:0]  rem_sh;
  logic        rem_ge;

  logic     in_range;
  count_t   cnt_cur;
  count_t   cnt_new;
  logic     acc;

  assign ctrl      = ucode(step_r);
  assign in_tready = (ctrl.op == OP_LOAD) & mem_ready;
  assign in_fire   = in_tvalid & in_tready;
  assign out_busy  = out_valid_r & ~out_tready;

  assign short_path = (value_r < VALUE_W'(4)) | ~value_r[0];
  assign d_sq   = 12'(d_r) * 12'(d_r);
  assign sq_gt  = d_sq > 12'(value_r);
  assign rem_sh = {rem_r, dvd_r[VALUE_W-1]};
  assign rem_ge = rem_sh >= d_r;

  always_comb begin
    case (ctrl.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_NO_START: cond_true = ~in_fire;
      C_SMALL:    cond_true = short_path;
      C_SQ_GT:    cond_true = sq_gt;
      C_DIV_MORE: cond_true = bit_cnt_r != 4'(VALUE_W - 1);
      C_REM_NZ:   cond_true = rem_r != '0;
      C_OUT_BUSY: cond_true = out_busy;
      default:    cond_true = 1'b1;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      step_nxt = ctrl.target;
    end else if (ctrl.last) begin
      step_nxt = S_WAIT;
    end else begin
      step_nxt = step_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Count update for the finish step
  assign in_range = 32'(value_r) < VALUE_RANGE;

  always_comb begin
    cnt_cur = in_range ? rd_data : '0;
    cnt_new = cnt_cur;
    acc     = 1'b0;
    if (prime_r && in_range) begin
      if (!mode_r) begin
        acc = cnt_cur == '0;
        if (cnt_cur != COUNT_MAX) begin
          cnt_new = cnt_cur + count_t'(1);
        end
      end else if (cnt_cur != '0) begin
        cnt_new = cnt_cur - count_t'(1);
        acc     = 1'b1;
      end
    end
  end

  always_comb begin
    mreq.addr  = addr_t'(value_r);
    mreq.wdata = cnt_new;
    mreq.we    = (ctrl.op == OP_FINISH) & ~out_busy & prime_r & in_range;
  end

  always_comb begin
    prime_nxt = prime_r;
    case (ctrl.op)
      OP_CLASSIFY:  prime_nxt = (value_r >= VALUE_W'(2)) & ((value_r < VALUE_W'(4)) | value_r[0]);
      OP_DIV_CHECK: prime_nxt = rem_r != '0;
      default:      prime_nxt = prime_r;
    endcase
  end

  // Datapath registers, driven by the current control word
  always_ff @(posedge clk) begin
    prime_r <= prime_nxt;
    case (ctrl.op)
      OP_LOAD: begin
        if (in_fire) begin
          value_r <= in_tdata[VALUE_W-1:0];
          mode_r  <= in_tuser;
        end
      end
      OP_CLASSIFY: begin
        d_r <= 6'd3;
      end
      OP_DIV_INIT: begin
        rem_r     <= '0;
        dvd_r     <= value_r;
        bit_cnt_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r     <= rem_ge ? 5'(rem_sh - d_r) : 5'(rem_sh);
        dvd_r     <= {dvd_r[VALUE_W-2:0], 1'b0};
        bit_cnt_r <= bit_cnt_r + 4'd1;
      end
      OP_DIV_CHECK: begin
        d_r <= d_r + 6'd2;
      end
      default: begin
      end
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.op == OP_FINISH && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_FINISH && !out_busy) begin
      out_prime_r <= prime_r;
      out_acc_r   <= acc;
      out_cnt_r   <= OUT_CNT_W'(cnt_new);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_cnt_r, out_acc_r, out_prime_r};

  pdf_count_mem u_count_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mreq),
    .rd_data (rd_data),
    .ready   (mem_ready)
  );

endmodule
